// File: design/assert_macros.svh
// Assertion macros for the design files; only the regulator unit uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

// File: design/mfr_pkg.sv
// Types and constants of the median frame rate regulator.
package mfr_pkg;

    localparam int RATE_W     = 10;
    localparam int AGE_W      = 16;
    localparam int MIN_AGE_W  = 8;
    localparam int THR_W      = 5;
    localparam int ACT_W      = 2;
    localparam int COUNT_W    = 5;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [AGE_W-1:0]  age_seconds;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_limit;
        logic [RATE_W-1:0]  median_rate;
        logic [ACT_W-1:0]   action;
        logic [COUNT_W-1:0] window_count;
    } t_out;

    // Per-cycle commands broadcast to every window cell.
    typedef struct packed {
        logic shift;   // push a new sample into the line
        logic load;    // start a ranking pass
        logic step;    // one compare-and-rotate step
    } t_cell_ctl;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RAISE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOWER = 2'd2;
    localparam logic [ACT_W-1:0] ACT_HOLD  = 2'd3;

    localparam logic [RATE_W-1:0]    DESIRED_RESET = 10'd60;
    localparam logic [MIN_AGE_W-1:0] MIN_AGE_RESET = 8'd2;
    localparam logic [THR_W-1:0]     THRESH_RESET  = 5'd5;
    localparam logic [RATE_W-1:0]    LIMIT_RESET   = 10'd60;
    localparam logic [RATE_W-1:0]    LIMIT_MIN     = 10'd1;
    localparam logic [RATE_W-1:0]    LIMIT_MAX     = 10'd1023;
    localparam logic [RATE_W-1:0]    MAX_STEP      = 10'd10;
    localparam logic [RATE_W-1:0]    HOLD_BAND     = 10'd2;

endpackage

// File: design/median_frame_rate_regulator_unit.sv
// Median frame rate regulator: sample window, systolic median, limit update.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_in_data  (mfr_pkg::t_in)
//  out     | out       | o_out_valid / i_out_stall  | o_out_data (mfr_pkg::t_out)
//  cfg     | in        | i_cfg_we (no handshake)    | i_cfg_index, i_cfg_data
//
// One item at a time. A sample that is not evaluated goes from IDLE straight
// to DONE and then into the output register. An evaluated one passes LOAD,
// RANK, SEL, MED, DEC and DONE: the ranking pass rotates every sample once
// around the cell ring. Synchronous active-low reset clears control, limit
// and registers; the sample cells are not reset. A stalled result is held in
// the output register while the next item is taken in and worked on.
`include "assert_macros.svh"

module median_frame_rate_regulator_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mfr_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mfr_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(WINDOW_DEPTH + 1);            // fill and rank counts
    localparam int RW  = $clog2(WINDOW_DEPTH);                // ranking step counter
    localparam int TW  = (CW > mfr_pkg::THR_W) ? CW : mfr_pkg::THR_W;
    localparam logic [RW-1:0] STEP_LAST = RW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;   // snapshot visitors, clear counts
    localparam logic [2:0] S_RANK = 3'd2;   // WINDOW_DEPTH compare/rotate steps
    localparam logic [2:0] S_SEL  = 3'd3;   // pick the two middle values
    localparam logic [2:0] S_MED  = 3'd4;   // average them
    localparam logic [2:0] S_DEC  = 3'd5;   // steer the limit
    localparam logic [2:0] S_DONE = 3'd6;   // hand result to output register

    logic [2:0]                    r_state;
    logic [RW-1:0]                 r_step;
    logic [CW-1:0]                 r_fill;
    logic [mfr_pkg::RATE_W-1:0]    r_limit;
    logic [mfr_pkg::RATE_W-1:0]    r_desired;
    logic [mfr_pkg::MIN_AGE_W-1:0] r_min_age;
    logic [mfr_pkg::THR_W-1:0]     r_thresh;
    logic [mfr_pkg::RATE_W-1:0]    r_m1;
    logic [mfr_pkg::RATE_W-1:0]    r_m2;
    logic [mfr_pkg::RATE_W-1:0]    r_median;
    logic [mfr_pkg::ACT_W-1:0]     r_action;
    logic                          r_out_valid;
    mfr_pkg::t_out                 r_out;

    logic                          in_xfer;
    logic                          age_ok;
    logic                          out_free;
    logic [CW-1:0]                 n_fill;
    logic                          thresh_met;
    mfr_pkg::t_cell_ctl            cell_ctl;

    logic [mfr_pkg::RATE_W-1:0]    w_val  [WINDOW_DEPTH];
    logic [mfr_pkg::RATE_W-1:0]    w_vis  [WINDOW_DEPTH];
    logic                          w_visv [WINDOW_DEPTH];
    logic [CW-1:0]                 w_lt   [WINDOW_DEPTH];
    logic [CW-1:0]                 w_le   [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]       cell_valid;

    logic [CW-1:0]                 k_lo;
    logic [CW-1:0]                 k_hi;
    logic [mfr_pkg::RATE_W-1:0]    n_m1;
    logic [mfr_pkg::RATE_W-1:0]    n_m2;
    logic [mfr_pkg::RATE_W:0]      mid_sum;

    logic                          raise;
    logic [mfr_pkg::RATE_W-1:0]    delta;
    logic [mfr_pkg::STEP_W-1:0]    step_amt;
    logic [mfr_pkg::RATE_W:0]      up_sum;
    logic [mfr_pkg::RATE_W:0]      low_bound;
    logic                          act_move;
    logic [mfr_pkg::RATE_W-1:0]    n_limit;
    logic [mfr_pkg::ACT_W-1:0]     n_action;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign age_ok   = i_in_data.age_seconds >= mfr_pkg::AGE_W'(r_min_age);
    assign out_free = !r_out_valid || !i_out_stall;

    // fill after a push; newest sample sits in cell 0, oldest drops off the end
    assign n_fill     = (r_fill < FILL_FULL) ? (r_fill + CW'(1)) : r_fill;
    assign thresh_met = TW'(n_fill) >= TW'(r_thresh);

    always_comb begin
        cell_ctl       = '0;
        cell_ctl.shift = in_xfer && age_ok;
        cell_ctl.load  = (r_state == S_LOAD);
        cell_ctl.step  = (r_state == S_RANK);
    end

    // ---------------- cell chain / ring ----------------
    for (genvar gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
        localparam int PREV = (gi + WINDOW_DEPTH - 1) % WINDOW_DEPTH;

        assign cell_valid[gi] = CW'(gi) < r_fill;

        mfr_cell #(
            .CNT_W (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_valid     (cell_valid[gi]),
            .i_shift_val ((gi == 0) ? i_in_data.sample_rate : w_val[PREV]),
            .i_ring_vis  (w_vis[PREV]),
            .i_ring_visv (w_visv[PREV]),
            .o_val       (w_val[gi]),
            .o_vis       (w_vis[gi]),
            .o_visv      (w_visv[gi]),
            .o_lt        (w_lt[gi]),
            .o_le        (w_le[gi])
        );
    end

    // ---------------- median selection ----------------
    // A cell holds sorted position k when lt <= k < le. Equal values
    // may match together; they carry the same value, so OR is safe.
    assign k_lo = (r_fill - CW'(1)) >> 1;
    assign k_hi = r_fill >> 1;

    always_comb begin
        n_m1 = '0;
        n_m2 = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (cell_valid[i] && (w_lt[i] <= k_lo) && (k_lo < w_le[i])) begin
                n_m1 = n_m1 | w_val[i];
            end
            if (cell_valid[i] && (w_lt[i] <= k_hi) && (k_hi < w_le[i])) begin
                n_m2 = n_m2 | w_val[i];
            end
        end
    end

    assign mid_sum = {1'b0, r_m1} + {1'b0, r_m2};

    // ---------------- limit decision ----------------
    assign raise     = r_median < r_desired;
    assign delta     = raise ? (r_desired - r_median) : (r_median - r_desired);
    assign act_move  = delta >= mfr_pkg::HOLD_BAND;
    assign step_amt  = (delta > mfr_pkg::MAX_STEP) ? mfr_pkg::MAX_STEP[mfr_pkg::STEP_W-1:0]
                                                   : delta[mfr_pkg::STEP_W-1:0];
    assign up_sum    = {1'b0, r_limit} + (mfr_pkg::RATE_W+1)'(step_amt);
    assign low_bound = {1'b0, mfr_pkg::LIMIT_MIN} + (mfr_pkg::RATE_W+1)'(step_amt);

    always_comb begin
        n_limit  = r_limit;
        n_action = mfr_pkg::ACT_HOLD;
        if (act_move && raise) begin
            n_action = mfr_pkg::ACT_RAISE;
            n_limit  = (up_sum > {1'b0, mfr_pkg::LIMIT_MAX}) ? mfr_pkg::LIMIT_MAX
                                                             : up_sum[mfr_pkg::RATE_W-1:0];
        end else if (act_move) begin
            n_action = mfr_pkg::ACT_LOWER;
            n_limit  = ({1'b0, r_limit} < low_bound) ? mfr_pkg::LIMIT_MIN
                                                     : (r_limit - mfr_pkg::RATE_W'(step_amt));
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desired <= mfr_pkg::DESIRED_RESET;
            r_min_age <= mfr_pkg::MIN_AGE_RESET;
            r_thresh  <= mfr_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mfr_pkg::CFG_DESIRED: r_desired <= i_cfg_data;
                mfr_pkg::CFG_MIN_AGE: r_min_age <= i_cfg_data[mfr_pkg::MIN_AGE_W-1:0];
                mfr_pkg::CFG_THRESH:  r_thresh  <= i_cfg_data[mfr_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_fill  <= '0;
            r_limit <= mfr_pkg::LIMIT_RESET;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_median <= '0;
                        r_action <= mfr_pkg::ACT_NONE;
                        if (age_ok) begin
                            r_fill  <= n_fill;
                            r_state <= thresh_met ? S_LOAD : S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    r_step <= r_step + RW'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_m1    <= n_m1;
                    r_m2    <= n_m2;
                    r_state <= S_MED;
                end
                S_MED: begin
                    r_median <= mid_sum[mfr_pkg::RATE_W:1];
                    r_state  <= S_DEC;
                end
                S_DEC: begin
                    r_limit  <= n_limit;
                    r_action <= n_action;
                    if (act_move) begin
                        r_fill <= '0;   // window emptied after a move
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out.rate_limit   <= r_limit;
            r_out.median_rate  <= r_median;
            r_out.action       <= r_action;
            r_out.window_count <= mfr_pkg::COUNT_W'(r_fill);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_fill_bound, r_fill <= FILL_FULL, "window fill exceeds depth")
    `ASSERT_ALWAYS(a_limit_nonzero, r_limit != '0, "rate limit fell to zero")
    `ASSERT_IMPLY(a_move_clears,
        o_out_valid && ((o_out_data.action == mfr_pkg::ACT_RAISE) ||
                        (o_out_data.action == mfr_pkg::ACT_LOWER)),
        o_out_data.window_count == '0, "window not emptied after limit move")
    `ASSERT_IMPLY(a_none_no_median,
        o_out_valid && (o_out_data.action == mfr_pkg::ACT_NONE),
        o_out_data.median_rate == '0, "median reported without evaluation")

endmodule

// File: design/mfr_cell.sv
// One window cell: holds a sample, ranks it against a rotating visitor.
module mfr_cell #(
    parameter int CNT_W = 5
) (
    input  logic                       i_clk,
    input  mfr_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_valid,
    input  logic [mfr_pkg::RATE_W-1:0] i_shift_val,
    input  logic [mfr_pkg::RATE_W-1:0] i_ring_vis,
    input  logic                       i_ring_visv,
    output logic [mfr_pkg::RATE_W-1:0] o_val,
    output logic [mfr_pkg::RATE_W-1:0] o_vis,
    output logic                       o_visv,
    output logic [CNT_W-1:0]           o_lt,
    output logic [CNT_W-1:0]           o_le
);

    logic [mfr_pkg::RATE_W-1:0] r_val;
    logic [mfr_pkg::RATE_W-1:0] r_vis;
    logic                       r_visv;
    logic [CNT_W-1:0]           r_lt;
    logic [CNT_W-1:0]           r_le;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val <= i_shift_val;
        end
        if (i_ctl.load) begin
            r_vis  <= r_val;
            r_visv <= i_valid;
            r_lt   <= '0;
            r_le   <= '0;
        end else if (i_ctl.step) begin
            // count the visitor, then hand it to the next cell
            if (r_visv && (r_vis < r_val)) begin
                r_lt <= r_lt + CNT_W'(1);
            end
            if (r_visv && (r_vis <= r_val)) begin
                r_le <= r_le + CNT_W'(1);
            end
            r_vis  <= i_ring_vis;
            r_visv <= i_ring_visv;
        end
    end

    assign o_val  = r_val;
    assign o_vis  = r_vis;
    assign o_visv = r_visv;
    assign o_lt   = r_lt;
    assign o_le   = r_le;

endmodule

// File: test/median_frame_rate_regulator_unit_test.sv
// Testbench for the median frame rate regulator: directed and random stimulus against a predictor.
`timescale 1ns / 1ps

module median_frame_rate_regulator_unit_test;

    localparam int WINDOW_DEPTH = 16;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 30;     // longer than an evaluated item
    localparam int DRAIN_BOUND  = 5000;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 45;
    localparam logic [mfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind it

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mfr_pkg::t_in                   in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mfr_pkg::t_out                  out_data;
    logic                           cfg_we    = 1'b0;
    logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index = mfr_pkg::CFG_DESIRED;
    logic [mfr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and the state
    logic [mfr_pkg::RATE_W-1:0]    target_rate    = mfr_pkg::DESIRED_RESET;
    logic [mfr_pkg::MIN_AGE_W-1:0] min_age        = mfr_pkg::MIN_AGE_RESET;
    logic [mfr_pkg::THR_W-1:0]     eval_threshold = mfr_pkg::THRESH_RESET;
    logic [mfr_pkg::RATE_W-1:0]    win_rate [WINDOW_DEPTH];
    int unsigned                   win_fill       = 0;
    int unsigned                   win_head       = 0;
    int unsigned                   limit_now      = mfr_pkg::LIMIT_RESET;

    mfr_pkg::t_out pending_verdicts [$];
    int            mismatch_count = 0;
    bit            idle_on = 1'b1;

    always #(CLK_HALF) clk = ~clk;

    median_frame_rate_regulator_unit #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Median of the held samples, oldest first; even counts round down.
    function automatic int unsigned median_of_window();
        int unsigned ranked [WINDOW_DEPTH];
        int unsigned key;
        int          j;
        for (int i = 0; i < win_fill; i++) begin
            ranked[i] = win_rate[(win_head + i) % WINDOW_DEPTH];
        end
        // insertion sort, window is tiny
        for (int i = 1; i < win_fill; i++) begin
            key = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > key) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        if (win_fill % 2 == 0) begin
            return (ranked[win_fill/2 - 1] + ranked[win_fill/2]) / 2;
        end
        return ranked[win_fill/2];
    endfunction

    // Advances the predicted state by one sample and returns the verdict it yields.
    function automatic mfr_pkg::t_out regulate_sample(mfr_pkg::t_in item);
        mfr_pkg::t_out verdict;
        int unsigned   med;
        int unsigned   delta;
        int unsigned   stride;
        bit            raise;
        verdict.median_rate = '0;
        verdict.action      = mfr_pkg::ACT_NONE;
        if (item.age_seconds >= min_age) begin
            // window keeps the newest samples, overwriting the oldest when full
            if (win_fill < WINDOW_DEPTH) begin
                win_rate[(win_head + win_fill) % WINDOW_DEPTH] = item.sample_rate;
                win_fill++;
            end else begin
                win_rate[win_head] = item.sample_rate;
                win_head = (win_head + 1) % WINDOW_DEPTH;
            end
            if (win_fill >= eval_threshold) begin
                med   = median_of_window();
                raise = med < target_rate;
                delta = raise ? target_rate - med : med - target_rate;
                if (delta >= mfr_pkg::HOLD_BAND) begin
                    stride = (delta > mfr_pkg::MAX_STEP) ? mfr_pkg::MAX_STEP : delta;
                    if (raise) begin
                        limit_now = (limit_now + stride > mfr_pkg::LIMIT_MAX)
                                  ? mfr_pkg::LIMIT_MAX : limit_now + stride;
                        verdict.action = mfr_pkg::ACT_RAISE;
                    end else begin
                        limit_now = (limit_now < mfr_pkg::LIMIT_MIN + stride)
                                  ? mfr_pkg::LIMIT_MIN : limit_now - stride;
                        verdict.action = mfr_pkg::ACT_LOWER;
                    end
                    win_fill = 0;
                    win_head = 0;
                end else begin
                    verdict.action = mfr_pkg::ACT_HOLD;
                end
                verdict.median_rate = med[mfr_pkg::RATE_W-1:0];
            end
        end
        verdict.rate_limit   = limit_now[mfr_pkg::RATE_W-1:0];
        verdict.window_count = win_fill[mfr_pkg::COUNT_W-1:0];
        return verdict;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // Every output transfer is matched against the oldest pending verdict.
    always @(posedge clk) begin : check_verdicts
        mfr_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = pending_verdicts[0];
                pending_verdicts.delete(0);
                check_field("rate_limit",   out_data.rate_limit,   want.rate_limit);
                check_field("median_rate",  out_data.median_rate,  want.median_rate);
                check_field("action",       out_data.action,       want.action);
                check_field("window_count", out_data.window_count, want.window_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Idling on both sides
    // ------------------------------------------------------------------

    // Mostly zero or short, now and then long; zero when idling is off.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_stall
        int span;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0) begin
                span = idle_span();
                if (span > 0) begin
                    out_stall <= 1'b1;
                    repeat (span) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transfer; valid stays high into the next call when there is no gap.
    task automatic send_sample(input int unsigned rate, input int unsigned age);
        mfr_pkg::t_in item;
        int           gap;
        item.sample_rate = rate[mfr_pkg::RATE_W-1:0];
        item.age_seconds = age[mfr_pkg::AGE_W-1:0];
        gap = idle_span();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        pending_verdicts.insert(pending_verdicts.size(), regulate_sample(item));
    endtask

    // Sender holds off until every pending verdict has come back.
    task automatic drain_verdicts();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending_verdicts.size() != 0 && waited < DRAIN_BOUND);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [mfr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mfr_pkg::CFG_DATA_W-1:0] word);
        drain_verdicts();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            mfr_pkg::CFG_DESIRED: target_rate    = word[mfr_pkg::RATE_W-1:0];
            mfr_pkg::CFG_MIN_AGE: min_age        = word[mfr_pkg::MIN_AGE_W-1:0];
            mfr_pkg::CFG_THRESH:  eval_threshold = word[mfr_pkg::THR_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits above each register's width are junk and must be dropped.
    task automatic apply_settings(input int unsigned desired, input int unsigned age_floor,
                                  input int unsigned threshold);
        write_register(mfr_pkg::CFG_DESIRED, desired[mfr_pkg::RATE_W-1:0]);
        write_register(mfr_pkg::CFG_MIN_AGE,
                       {2'($urandom_range(0, 3)), age_floor[mfr_pkg::MIN_AGE_W-1:0]});
        write_register(mfr_pkg::CFG_THRESH,
                       {5'($urandom_range(0, 31)), threshold[mfr_pkg::THR_W-1:0]});
    endtask

    function automatic int unsigned pick_rate();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            s = int'(target_rate) + int'($urandom_range(0, 6)) - 3;     // hold band
        end else if (r < 75) begin
            s = int'(target_rate) + int'($urandom_range(0, 24)) - 12;   // around full step
        end else if (r < 80) begin
            s = ($urandom_range(0, 1) == 1) ? 1023 : 0;
        end else begin
            s = $urandom_range(0, 1023);
        end
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        return s;
    endfunction

    function automatic int unsigned pick_age();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return min_age;
        if (r < 10) return 65535;
        return $urandom_range(min_age, 65535);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_young_state();
        // reset settings: samples younger than two seconds are dropped
        send_sample(1023, 0);
        send_sample(0, 1);
        send_sample(512, 2);
    endtask

    task automatic test_median_windows();
        // odd window of five with outliers, then an even pair rounding down
        send_sample(0, 65535);
        send_sample(1023, 65535);
        send_sample(64, 65535);
        send_sample(62, 65535);
        write_register(mfr_pkg::CFG_THRESH, 10'd2);
        send_sample(10, 3);
        send_sample(13, 4);
    endtask

    task automatic test_step_sizes();
        write_register(mfr_pkg::CFG_THRESH, 10'd1);
        write_register(mfr_pkg::CFG_MIN_AGE, 10'd0);
        send_sample(70, 0);    // exactly ten over: full step down
        send_sample(71, 0);    // eleven over: step clipped to ten
        send_sample(62, 0);    // two over: smallest move
        send_sample(61, 0);    // one over: held, window kept
        send_sample(58, 0);    // median one under: held
        send_sample(48, 0);    // median two under: raised
    endtask

    task automatic test_register_extremes();
        write_register(CFG_SPARE, '1);                   // unmapped index, no effect
        write_register(mfr_pkg::CFG_THRESH, 10'd0);      // threshold zero: evaluate every sample
        write_register(mfr_pkg::CFG_DESIRED, 10'd0);     // target zero drives limit to the floor
        repeat (7) send_sample(1023, $urandom_range(0, 65535));
        write_register(mfr_pkg::CFG_MIN_AGE, 10'd255);
        send_sample(600, 254);
        send_sample(600, 255);
        write_register(mfr_pkg::CFG_THRESH, 10'd31);     // threshold past depth: never evaluated
        send_sample(1023, 65535);
        send_sample(0, 300);
    endtask

    task automatic test_random_regulation();
        int r;
        int quota;
        int sent;
        int unsigned desired;
        int unsigned age_floor;
        int unsigned threshold;
        // first phase climbs to the ceiling, the rest pick settings at random
        for (int phase = 0; phase <= RANDOM_PHASES; phase++) begin
            idle_on = (phase % 3 != 2);
            r = $urandom_range(0, 99);
            desired = (r < 15) ? 1023 : (r < 25) ? 1 : (r < 30) ? 0 : $urandom_range(1, 1023);
            r = $urandom_range(0, 99);
            age_floor = (r < 10) ? 255 : (r < 30) ? 0 : (r < 80) ? $urandom_range(0, 8)
                                                              : $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            threshold = (r < 15) ? $urandom_range(17, 31) : (r < 25) ? 0
                      : (r < 40) ? 16 : $urandom_range(1, 15);
            quota = PHASE_ITEMS;
            case (phase)
                0: begin
                    desired = 1023;
                    age_floor = 0;
                    threshold = 1;
                    quota = 110;
                end
                1: threshold = 20;    // window wraps with no evaluation
                2: threshold = 16;
                default: ;
            endcase
            apply_settings(desired, age_floor, threshold);
            sent = 0;
            while (sent < quota) begin
                if ($urandom_range(0, 99) < 2) begin
                    drain_verdicts();
                end
                if (phase == 0) begin
                    send_sample($urandom_range(0, 900), $urandom_range(0, 65535));
                    sent++;
                end else if (min_age > 0 && $urandom_range(0, 99) < 12) begin
                    send_sample($urandom_range(0, 1023), $urandom_range(0, min_age - 1));
                end else begin
                    send_sample(pick_rate(), pick_age());
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_young_state();
        test_median_windows();
        test_step_sizes();
        test_register_extremes();
        test_random_regulation();

        drain_verdicts();
        repeat (SETTLE) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        end
        if (mismatch_count == 0) begin
            $display("median_frame_rate_regulator_unit_test OK");
        end else begin
            $display("median_frame_rate_regulator_unit_test NOT OK");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #(12_000_000);
        $display("median_frame_rate_regulator_unit_test NOT OK");
        $finish;
    end

endmodule
